[src/tpdc_pkg.sv]
`default_nettype none
package tpdc_pkg;

    localparam int POS_BITS_DEF = 48;
    localparam int IO_POS_BITS  = 48;
    localparam int QUANT_BITS   = 16;
    localparam int VAL_BITS     = 24;
    localparam int ROUND_BITS   = VAL_BITS + 1;
    localparam int FRAME_BITS   = 16;
    localparam int KIND_BITS    = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [QUANT_BITS-1:0] QUANT_RESET = QUANT_BITS'(512);

    localparam logic [KIND_BITS-1:0] KIND_TIMING = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_SETPOS = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_START  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_STOP   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_PAUSE  = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_RESUME = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_TICK   = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 3'd7;

    localparam logic [CFG_IDX_BITS-1:0] REG_QUANTUM = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEAD_IN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TAIL    = 2'd2;

endpackage
`default_nettype wire

[src/tpdc_round_unit.sv]
`default_nettype none
module tpdc_round_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [tpdc_pkg::VAL_BITS-1:0]       value,
    input  wire logic [tpdc_pkg::QUANT_BITS-1:0]     quantum,
    output logic                                     done,
    output logic [tpdc_pkg::ROUND_BITS-1:0]          result
);

    localparam int VB = tpdc_pkg::VAL_BITS;
    localparam int QB = tpdc_pkg::QUANT_BITS;
    localparam int CB = $clog2(VB);
    localparam logic [CB-1:0] LAST_STEP = CB'(VB - 1);

    typedef enum logic [2:0] {
        RU_IDLE = 3'b001,
        RU_RUN  = 3'b010,
        RU_FIX  = 3'b100
    } ru_state_t;

    ru_state_t           state_reg;
    logic                done_reg;
    logic [CB-1:0]       cnt_reg;
    logic [VB-1:0]       shift_reg;
    logic [VB-1:0]       val_reg;
    logic [QB-1:0]       q_reg;
    logic [QB-1:0]       rem_reg;
    logic [QB-1:0]       rem_next;
    logic [tpdc_pkg::ROUND_BITS-1:0] result_reg;

    logic [QB:0]         trial;
    logic [QB:0]         diff;
    logic [QB-1:0]       pad;

    // one restoring remainder step per cycle, msb first
    always_comb begin
        trial    = {rem_reg, shift_reg[VB-1]};
        diff     = trial - {1'b0, q_reg};
        rem_next = (trial >= {1'b0, q_reg}) ? diff[QB-1:0] : trial[QB-1:0];
        pad      = (rem_reg == '0) ? '0 : (q_reg - rem_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RU_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                RU_IDLE: begin
                    done_reg <= 1'b0;
                    if (start) begin
                        state_reg <= RU_RUN;
                        cnt_reg   <= '0;
                    end
                end
                RU_RUN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= RU_FIX;
                    end
                end
                RU_FIX: begin
                    done_reg  <= 1'b1;
                    state_reg <= RU_IDLE;
                end
                default: begin
                    state_reg <= RU_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            RU_IDLE: begin
                if (start) begin
                    shift_reg <= value;
                    val_reg   <= value;
                    q_reg     <= quantum;
                    rem_reg   <= '0;
                end
            end
            RU_RUN: begin
                rem_reg   <= rem_next;
                shift_reg <= {shift_reg[VB-2:0], 1'b0};
            end
            RU_FIX: begin
                result_reg <= {1'b0, val_reg} + tpdc_pkg::ROUND_BITS'(pad);
            end
            default: begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

[src/transport_preroll_drain_control.sv]
`default_nettype none
// Transport controller for an audio engine: each request on the s_ stream is one command
// (timing update, set position, start, stop, pause, resume or block tick) and yields one
// result on the m_ stream with the audible and render positions after it, the drain flag
// and the delay-line clear flag. From acceptance a command runs through the load, wait and
// apply states; in the wait state the bit-serial remainder unit rounds the lead-in or the
// stop tail up to the block quantum, one dividend bit per cycle. No new request is taken
// before the last command is done: s_tready is high only while no command is in work. A
// finished result waits in the output register without holding up the next request, but
// that next command holds in its apply state until the earlier result has been taken.
// The configuration port is always ready and must only be written while idle.
module transport_preroll_drain_control #(
    parameter int POS_BITS = tpdc_pkg::POS_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // new_position[47:0], playing[48], frame_count[64:49], zero fill above
    input  wire logic [71:0]                          s_tdata,
    // kind[2:0]
    input  wire logic [tpdc_pkg::KIND_BITS-1:0]       s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // audible_position[47:0], render_position[95:48], draining[96],
    // clear_delay_lines[97], zero fill above
    output logic [103:0]                              m_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tpdc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [tpdc_pkg::VAL_BITS-1:0]        cfg_data
);

    localparam int IOB = tpdc_pkg::IO_POS_BITS;
    localparam int RB  = tpdc_pkg::ROUND_BITS;
    localparam int FB  = tpdc_pkg::FRAME_BITS;
    localparam int QB  = tpdc_pkg::QUANT_BITS;
    localparam int VB  = tpdc_pkg::VAL_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_APPLY = 4'b1000
    } state_t;

    state_t                          state_reg;
    logic [QB-1:0]                   quant_reg;
    logic [VB-1:0]                   lead_reg;
    logic [VB-1:0]                   tail_reg;

    logic [POS_BITS-1:0]             aud_reg, aud_next;
    logic [POS_BITS-1:0]             rend_reg, rend_next;
    logic                            active_reg, active_next;
    logic [RB-1:0]                   left_reg, left_next;
    logic                            rewind_reg, rewind_next;

    logic [tpdc_pkg::KIND_BITS-1:0]  kind_reg;
    logic [POS_BITS-1:0]             npos_reg;
    logic                            playing_reg;
    logic [FB-1:0]                   frames_reg;

    logic                            mvalid_reg;
    logic [IOB-1:0]                  out_aud_reg;
    logic [IOB-1:0]                  out_rend_reg;
    logic                            out_drain_reg;
    logic                            out_clr_reg;

    logic                            rnd_start;
    logic                            rnd_done;
    logic [RB-1:0]                   rnd_result;
    logic [QB-1:0]                   quant_eff;
    logic [VB-1:0]                   rnd_value;

    logic signed [IOB-1:0]           in_pos;
    logic signed [63:0]              in_pos_ext;
    logic                            do_preroll;
    logic [POS_BITS-1:0]             preroll_base;
    logic [POS_BITS-1:0]             preroll_rend;
    logic [POS_BITS-1:0]             tick_rend;
    logic                            out_free;
    logic                            clr;
    logic signed [POS_BITS-1:0]      aud_s;
    logic signed [POS_BITS-1:0]      rend_s;
    logic signed [63:0]              aud_ext;
    logic signed [63:0]              rend_ext;

    assign quant_eff = (quant_reg == '0) ? QB'(1) : quant_reg;
    assign rnd_value = (kind_reg == tpdc_pkg::KIND_STOP) ? tail_reg : lead_reg;
    assign rnd_start = (state_reg == ST_LOAD);

    tpdc_round_unit u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rnd_start),
        .value   (rnd_value),
        .quantum (quant_eff),
        .done    (rnd_done),
        .result  (rnd_result)
    );

    assign in_pos     = s_tdata[IOB-1:0];
    assign in_pos_ext = 64'(in_pos);
    assign out_free   = !mvalid_reg || m_tready;

    always_comb begin
        aud_next    = aud_reg;
        rend_next   = rend_reg;
        active_next = active_reg;
        left_next   = left_reg;
        rewind_next = rewind_reg;
        do_preroll  = 1'b0;
        preroll_base = aud_reg;
        tick_rend   = rend_reg + POS_BITS'(frames_reg);

        case (kind_reg)
            tpdc_pkg::KIND_TIMING: begin
                do_preroll = playing_reg;
            end
            tpdc_pkg::KIND_SETPOS: begin
                do_preroll   = playing_reg;
                preroll_base = npos_reg;
            end
            tpdc_pkg::KIND_START: begin
                do_preroll   = 1'b1;
                preroll_base = '0;
            end
            tpdc_pkg::KIND_RESUME: begin
                do_preroll = 1'b1;
            end
            default: begin
                do_preroll = 1'b0;
            end
        endcase

        preroll_rend = preroll_base - POS_BITS'(rnd_result);

        case (kind_reg)
            tpdc_pkg::KIND_TIMING, tpdc_pkg::KIND_SETPOS, tpdc_pkg::KIND_PAUSE: begin
                active_next = 1'b0;
                left_next   = '0;
                rewind_next = 1'b0;
                aud_next    = preroll_base;
                rend_next   = do_preroll ? preroll_rend : preroll_base;
            end
            tpdc_pkg::KIND_START, tpdc_pkg::KIND_RESUME: begin
                active_next = 1'b0;
                left_next   = '0;
                rewind_next = 1'b0;
                aud_next    = preroll_base;
                rend_next   = preroll_rend;
            end
            tpdc_pkg::KIND_STOP: begin
                if (tail_reg != '0) begin
                    active_next = 1'b1;
                    left_next   = rnd_result;
                    rewind_next = 1'b1;
                end else begin
                    active_next = 1'b0;
                    left_next   = '0;
                    rewind_next = 1'b0;
                    aud_next    = '0;
                    rend_next   = '0;
                end
            end
            tpdc_pkg::KIND_TICK: begin
                if (active_reg) begin
                    rend_next = tick_rend;
                    if (left_reg > RB'(frames_reg)) begin
                        left_next = left_reg - RB'(frames_reg);
                    end else begin
                        active_next = 1'b0;
                        left_next   = '0;
                        rewind_next = 1'b0;
                        if (rewind_reg) begin
                            aud_next  = '0;
                            rend_next = '0;
                        end
                    end
                end
            end
            default: begin
                aud_next = aud_reg;
            end
        endcase

        clr = (kind_reg != tpdc_pkg::KIND_TICK) && (kind_reg != tpdc_pkg::KIND_UNUSED);
        aud_s    = aud_next;
        rend_s   = rend_next;
        aud_ext  = 64'(aud_s);
        rend_ext = 64'(rend_s);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            quant_reg  <= tpdc_pkg::QUANT_RESET;
            lead_reg   <= '0;
            tail_reg   <= '0;
            aud_reg    <= '0;
            rend_reg   <= '0;
            active_reg <= 1'b0;
            left_reg   <= '0;
            rewind_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    tpdc_pkg::REG_QUANTUM: quant_reg <= cfg_data[QB-1:0];
                    tpdc_pkg::REG_LEAD_IN: lead_reg  <= cfg_data;
                    tpdc_pkg::REG_TAIL:    tail_reg  <= cfg_data;
                    default:               quant_reg <= quant_reg;
                endcase
            end
            // the apply step below sets valid again when it reloads the output
            if (mvalid_reg && m_tready && state_reg != ST_APPLY) begin
                mvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (rnd_done) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (out_free) begin
                        aud_reg    <= aud_next;
                        rend_reg   <= rend_next;
                        active_reg <= active_next;
                        left_reg   <= left_next;
                        rewind_reg <= rewind_next;
                        mvalid_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // request capture and result payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            kind_reg    <= s_tuser;
            npos_reg    <= in_pos_ext[POS_BITS-1:0];
            playing_reg <= s_tdata[IOB];
            frames_reg  <= s_tdata[IOB+FB:IOB+1];
        end
        if (state_reg == ST_APPLY && out_free) begin
            out_aud_reg   <= aud_ext[IOB-1:0];
            out_rend_reg  <= rend_ext[IOB-1:0];
            out_drain_reg <= active_next;
            out_clr_reg   <= clr;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {6'd0, out_clr_reg, out_drain_reg, out_rend_reg, out_aud_reg};

endmodule
`default_nettype wire
